/* rtl/dmf_pkg.sv */
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared widths, defaults and operation codes of the duplicate message filter.
// ----------------------------------------------------------------------------
package dmf_pkg;

   // Default number of pairs held by the ring
   localparam int DMF_CAPACITY_DEF = 32;

   // Field widths of one request and one response word
   localparam int OP_W    = 2;
   localparam int SEQ_W   = 8;
   localparam int ADDR_W  = 16;
   localparam int KEY_W   = SEQ_W + ADDR_W;
   localparam int COUNT_W = 6;

   // Operation codes; the unused code changes nothing
   typedef enum logic [OP_W-1:0] {
      OP_CHECK_ADD = 2'd0,
      OP_QUERY     = 2'd1,
      OP_EXPIRE    = 2'd2
   } op_type;

endpackage

/* rtl/dmf_ram.sv */
// ----------------------------------------------------------------------------
// dmf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read; read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/duplicate_message_filter_core.sv */
// ----------------------------------------------------------------------------
// duplicate_message_filter_core
// FIFO ring of recently seen (sequence number, source address) pairs.
// ----------------------------------------------------------------------------
// One request word is processed at a time. Check-and-add and query scan the
// held pairs from oldest to newest through the single read port of the pair
// RAM, one slot per cycle, and stop at the first match; expire and the unused
// op code skip the scan. The response is loaded when the scan stops, at the
// first match or after the last held pair, and without a scan for an empty
// ring, expire or the unused op code. The worst case is a full ring with no
// match, set by the one-slot-per-cycle scan of the RAM read port. The next
// request is taken on the cycle after the response is loaded. The response
// sits in an output register, so a new request is taken while it waits. A
// stalled response holds back only the loading of the next one. A full ring
// drops its oldest pair on append. No clearing pass runs after reset.
module duplicate_message_filter_core
   import dmf_pkg::*;
#(
   parameter int CAPACITY = DMF_CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_op,
   input  logic [SEQ_W-1:0]   req_seq_number,
   input  logic [ADDR_W-1:0]  req_source_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [COUNT_W-1:0] rsp_entry_count
);

   localparam int Slots = CAPACITY + 1;
   localparam int IdxW  = $clog2(Slots);

   typedef logic [IdxW-1:0] idx_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   function automatic idx_type ring_next(input idx_type i);
      ring_next = (i == idx_type'(CAPACITY)) ? '0 : i + 1'b1;
   endfunction

   state_type         state_ff, state_in;
   idx_type           oldest_ff, oldest_in;
   idx_type           next_ff, next_in;
   idx_type           count_ff, count_in;
   idx_type           rd_idx_ff, rd_idx_in;
   idx_type           left_ff, left_in;
   logic              pend_ff, pend_in;
   logic              hit_ff, hit_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic              accept;
   logic              finish;
   logic              match;
   logic              rd_en;
   logic              wr_en;
   logic [KEY_W-1:0]  rd_data;

   // Pair storage; reads happen only in scan, the write only in finish,
   // so accesses never overlap
   dmf_ram #(
      .WIDTH (KEY_W),
      .DEPTH (Slots)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (next_ff),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rd_en     = (state_ff == ST_SCAN) && (left_ff != '0);
   assign match     = (state_ff == ST_SCAN) && pend_ff && (rd_data == key_ff);
   assign finish    = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign wr_en     = finish && (op_ff == OP_CHECK_ADD) && !hit_ff;

   // Sequence one word: accept, scan, update and respond
   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      next_in      = next_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      left_in      = left_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               key_in    = {req_seq_number, req_source_address};
               hit_in    = 1'b0;
               rd_idx_in = oldest_ff;
               left_in   = count_ff;
               if ((req_op == OP_CHECK_ADD || req_op == OP_QUERY) && count_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            // Issue the next slot, compare the one read last cycle
            if (left_ff != '0) begin
               rd_idx_in = ring_next(rd_idx_ff);
               left_in   = left_ff - 1'b1;
               pend_in   = 1'b1;
            end
            if (match) begin
               hit_in = 1'b1;
            end
            if (match || (left_ff == '0 && !pend_ff)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish) begin
               unique case (op_ff)
                  OP_CHECK_ADD: begin
                     if (!hit_ff) begin
                        next_in = ring_next(next_ff);
                        if (count_ff == idx_type'(CAPACITY)) begin
                           oldest_in = ring_next(oldest_ff);
                        end else begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  OP_EXPIRE: begin
                     if (count_ff != '0) begin
                        oldest_in = ring_next(oldest_ff);
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_count_in = COUNT_W'(count_in);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state, clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         next_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         next_ff      <= next_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      left_ff      <= left_in;
      hit_ff       <= hit_in;
      op_ff        <= op_in;
      key_ff       <= key_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
